// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master bit engine: command and response
// items, operation, phase and status codes, transmit queue request/status.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_DOUT  = 3'd1,
    PH_RACK  = 3'd2,
    PH_DIN   = 3'd3,
    PH_GACK  = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  localparam int unsigned BitsPerByte = 8;

  typedef struct packed {
    logic [1:0]  operation;
    logic        sda_in;
    logic [7:0]  data_byte;
    logic [15:0] receive_count;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    logic [1:0] bus_status;
    logic       push_dropped;
  } rsp_item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_byte;
  } txq_req_t;

  typedef struct packed {
    logic       full;
    logic       nonempty;
    logic [7:0] head_byte;
  } txq_stat_t;

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface i2cm_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/i2cm_ram.sv =====
// ----------------------------------------------------------------------------
// i2cm_ram
// Generic single write port, single read port RAM with registered read data
// (read returns the contents before a same-cycle write).
// ----------------------------------------------------------------------------
module i2cm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/i2cm_txq.sv =====
// ----------------------------------------------------------------------------
// i2cm_txq
// Transmit byte queue: head/tail/fill pointers around a RAM, with the head
// byte prefetched every cycle and a forward path for a write to the head slot.
// ----------------------------------------------------------------------------
module i2cm_txq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  i2cm_pkg::txq_req_t  req,
  output i2cm_pkg::txq_stat_t stat
);
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FillW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(DEPTH);

  logic [IdxW-1:0]  head;
  logic [IdxW-1:0]  head_next;
  logic [IdxW-1:0]  tail;
  logic [IdxW-1:0]  tail_next;
  logic [FillW-1:0] fill;
  logic [FillW-1:0] fill_next;
  logic [7:0]       ram_q;
  logic             fwd_hit;
  logic [7:0]       fwd_byte;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (req.pop) begin
      head_next = (head == LastIdx) ? '0 : head + IdxW'(1);
      fill_next = fill - FillW'(1);
    end
    if (req.push) begin
      tail_next = (tail == LastIdx) ? '0 : tail + IdxW'(1);
      fill_next = fill + FillW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      fwd_hit <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      fill    <= fill_next;
      fwd_hit <= req.push && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    fwd_byte <= req.push_byte;
  end

  i2cm_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (req.push),
    .wr_addr(tail),
    .wr_data(req.push_byte),
    .rd_addr(head_next),
    .rd_data(ram_q)
  );

  assign stat.full      = (fill == FullFill);
  assign stat.nonempty  = (fill != '0);
  assign stat.head_byte = fwd_hit ? fwd_byte : ram_q;
endmodule

// ===== hw/rtl/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// i2cm_core
// Half-bit phase machine and bus state: start, shift out, ack sample, shift
// in, ack drive and stop; builds one response per command.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  i2cm_pkg::cmd_item_t   item,
  input  i2cm_pkg::txq_stat_t   txq_stat,
  output i2cm_pkg::txq_req_t    txq_req,
  output i2cm_pkg::rsp_item_t   result
);
  i2cm_pkg::phase_t  phase;
  i2cm_pkg::phase_t  phase_next;
  i2cm_pkg::status_t status_code;
  i2cm_pkg::status_t status_code_next;
  logic        clock_phase;
  logic        clock_phase_next;
  logic [7:0]  shift_byte;
  logic [7:0]  shift_byte_next;
  logic [3:0]  bit_counter;
  logic [3:0]  bit_counter_next;
  logic [7:0]  target_addr;
  logic [7:0]  target_addr_next;
  logic [15:0] remaining_rx;
  logic [15:0] remaining_rx_next;
  logic        active;
  logic        active_next;
  logic        scl_level;
  logic        scl_level_next;
  logic        sda_level;
  logic        sda_level_next;

  logic        is_tick;
  logic        is_start;
  logic        is_push;
  logic [3:0]  cnt_inc;
  logic [7:0]  shift_in;
  logic [15:0] rem_dec;
  logic        byte_end;
  logic        tx_more;

  assign is_tick  = advance && (item.operation == i2cm_pkg::OP_TICK) && active;
  assign is_start = advance && (item.operation == i2cm_pkg::OP_START) && !active;
  assign is_push  = advance && (item.operation == i2cm_pkg::OP_PUSH);
  assign cnt_inc  = bit_counter + 4'd1;
  assign shift_in = {shift_byte[6:0], item.sda_in};
  assign rem_dec  = remaining_rx - 16'd1;
  assign byte_end = (bit_counter == 4'(i2cm_pkg::BitsPerByte));
  assign tx_more  = !target_addr[0] && txq_stat.nonempty;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (is_start) begin
      phase_next = i2cm_pkg::PH_START;
    end else if (is_tick && !clock_phase) begin
      case (phase)
        i2cm_pkg::PH_START: phase_next = i2cm_pkg::PH_DOUT;
        i2cm_pkg::PH_DOUT: begin
          if (byte_end) begin
            phase_next = i2cm_pkg::PH_RACK;
          end
        end
        i2cm_pkg::PH_RACK: begin
          if (item.sda_in) begin
            phase_next = i2cm_pkg::PH_STOP;
          end else if (target_addr[0]) begin
            phase_next = i2cm_pkg::PH_DIN;
          end else if (tx_more) begin
            phase_next = i2cm_pkg::PH_DOUT;
          end else begin
            phase_next = i2cm_pkg::PH_STOP;
          end
        end
        i2cm_pkg::PH_DIN: begin
          if (cnt_inc == 4'(i2cm_pkg::BitsPerByte)) begin
            phase_next = (rem_dec == '0) ? i2cm_pkg::PH_STOP : i2cm_pkg::PH_GACK;
          end
        end
        i2cm_pkg::PH_GACK: phase_next = i2cm_pkg::PH_DIN;
        i2cm_pkg::PH_STOP: phase_next = i2cm_pkg::PH_START;
        default:           phase_next = phase;
      endcase
    end
  end

  // datapath and response
  always_comb begin
    clock_phase_next  = clock_phase;
    shift_byte_next   = shift_byte;
    bit_counter_next  = bit_counter;
    target_addr_next  = target_addr;
    remaining_rx_next = remaining_rx;
    status_code_next  = status_code;
    active_next       = active;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    txq_req.push      = is_push && !txq_stat.full;
    txq_req.pop       = 1'b0;
    txq_req.push_byte = item.data_byte;
    result.rx_byte    = '0;
    result.rx_valid   = 1'b0;
    result.done_res   = 1'b0;

    if (is_start) begin
      target_addr_next  = item.data_byte;
      remaining_rx_next = item.receive_count;
      bit_counter_next  = '0;
      shift_byte_next   = '0;
      status_code_next  = i2cm_pkg::ST_BUSY;
      active_next       = 1'b1;
    end else if (is_tick && !clock_phase) begin
      clock_phase_next = 1'b1;
      scl_level_next   = 1'b1;
      case (phase)
        i2cm_pkg::PH_START: begin
          sda_level_next   = 1'b0;
          shift_byte_next  = target_addr;
          bit_counter_next = '0;
        end
        i2cm_pkg::PH_DOUT: begin
          if (byte_end) begin
            bit_counter_next = '0;
            shift_byte_next  = '0;
          end
        end
        i2cm_pkg::PH_RACK: begin
          if (item.sda_in) begin
            status_code_next = i2cm_pkg::ST_ERR;
          end else if (tx_more) begin
            shift_byte_next = txq_stat.head_byte;
            txq_req.pop     = 1'b1;
          end
        end
        i2cm_pkg::PH_DIN: begin
          shift_byte_next  = shift_in;
          bit_counter_next = cnt_inc;
          if (cnt_inc == 4'(i2cm_pkg::BitsPerByte)) begin
            bit_counter_next  = '0;
            result.rx_byte    = shift_in;
            result.rx_valid   = 1'b1;
            shift_byte_next   = '0;
            remaining_rx_next = rem_dec;
          end
        end
        i2cm_pkg::PH_STOP: begin
          sda_level_next   = 1'b1;
          active_next      = 1'b0;
          clock_phase_next = 1'b0;
          if (status_code != i2cm_pkg::ST_ERR) begin
            status_code_next = i2cm_pkg::ST_OK;
          end
          result.done_res = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (is_tick) begin
      clock_phase_next = 1'b0;
      scl_level_next   = 1'b0;
      case (phase)
        i2cm_pkg::PH_DOUT: begin
          sda_level_next   = shift_byte[7];
          shift_byte_next  = {shift_byte[6:0], 1'b0};
          bit_counter_next = cnt_inc;
        end
        i2cm_pkg::PH_RACK, i2cm_pkg::PH_DIN:  sda_level_next = 1'b1;
        i2cm_pkg::PH_GACK, i2cm_pkg::PH_STOP: sda_level_next = 1'b0;
        default: begin
        end
      endcase
    end

    result.scl_out      = scl_level_next;
    result.sda_out      = sda_level_next;
    result.bus_status   = status_code_next;
    result.push_dropped = is_push && txq_stat.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cm_pkg::PH_START;
      status_code  <= i2cm_pkg::ST_OK;
      clock_phase  <= 1'b0;
      shift_byte   <= '0;
      bit_counter  <= '0;
      target_addr  <= '0;
      remaining_rx <= '0;
      active       <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
    end else begin
      phase        <= phase_next;
      status_code  <= status_code_next;
      clock_phase  <= clock_phase_next;
      shift_byte   <= shift_byte_next;
      bit_counter  <= bit_counter_next;
      target_addr  <= target_addr_next;
      remaining_rx <= remaining_rx_next;
      active       <= active_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
    end
  end
endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// A request is held in the command register, then its response in the response register.
// Throughput: one request per cycle, sustained, with a free response slot.
// While a response waits to be taken, the command register can still hold one request.
// Reset: SCL and SDA released, engine idle with status ok, transmit queue
// empty; the queue storage itself is not cleared.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: command register, phase machine with transmit queue,
// and response register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int unsigned TX_QUEUE_DEPTH = 16
) (
  input logic   clk,
  input logic   rst,
  i2cm_if.sink   cmd,
  i2cm_if.source rsp
);
  logic                cmd_valid;
  i2cm_pkg::cmd_item_t cmd_item;
  logic                rsp_valid;
  i2cm_pkg::rsp_item_t rsp_item;
  logic                advance;
  i2cm_pkg::rsp_item_t result;
  i2cm_pkg::txq_req_t  txq_req;
  i2cm_pkg::txq_stat_t txq_stat;

  assign advance   = cmd_valid && (!rsp_valid || rsp.ready);
  assign cmd.ready = !cmd_valid || advance;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.ready) begin
        cmd_valid <= cmd.valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_item <= cmd.data;
    end
    if (advance) begin
      rsp_item <= result;
    end
  end

  i2cm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (cmd_item),
    .txq_stat(txq_stat),
    .txq_req (txq_req),
    .result  (result)
  );

  i2cm_txq #(
    .DEPTH(TX_QUEUE_DEPTH)
  ) u_txq (
    .clk (clk),
    .rst (rst),
    .req (txq_req),
    .stat(txq_stat)
  );
endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the response channel of the I2C master bit engine.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input i2cm_pkg::rsp_item_t rsp_data
);
  // a stop leaves both lines released and the engine no longer busy
  a_done_released: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.done_res |->
      rsp_data.scl_out && rsp_data.sda_out &&
      (rsp_data.bus_status != i2cm_pkg::ST_BUSY))
    else $error("stop without released lines or still busy");

  // an engine reporting ok is idle and never pulls a line low
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.bus_status == i2cm_pkg::ST_OK) |->
      rsp_data.scl_out && rsp_data.sda_out)
    else $error("line driven low while idle");

  // a received byte completes on a high clock phase inside a transaction
  a_rx_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.rx_valid |->
      rsp_data.scl_out && !rsp_data.done_res &&
      (rsp_data.bus_status == i2cm_pkg::ST_BUSY))
    else $error("received byte outside a read transaction");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");
endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data (rsp.data)
);

// ===== tb/tb_i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// Self-checking bench for the I2C master bit engine. Requests (ticks, queue
// pushes, starts) are driven on the command channel with random gaps. A
// scoreboard keeps its own model of the bus phases and the transmit queue and
// compares every response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum {ACK_MOSTLY, NACK_ADDRESS, ACK_ALWAYS} ack_plan_t;

  class i2c_bit_scoreboard;
    int unsigned           qdepth;
    bit                    low_half_next;
    i2cm_pkg::phase_t      phase;
    logic [7:0]            shreg;
    logic [3:0]            nbits;
    logic [7:0]            addr_rw;
    logic [15:0]           rx_left;
    i2cm_pkg::status_t     status;
    bit                    active;
    logic                  scl;
    logic                  sda;
    logic [7:0]            txq [];
    int unsigned           head;
    int unsigned           tail;
    int unsigned           fill;
    i2cm_pkg::rsp_item_t   expected_rsp [$];
    int                    errors;

    function new(int unsigned depth);
      qdepth = depth;
      txq = new[depth];
      low_half_next = 1'b0;
      phase = i2cm_pkg::PH_START;
      shreg = '0;
      nbits = '0;
      addr_rw = '0;
      rx_left = '0;
      status = i2cm_pkg::ST_OK;
      active = 1'b0;
      scl = 1'b1;
      sda = 1'b1;
      head = 0;
      tail = 0;
      fill = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // next tick is the high half with the engine sitting on the ack slot
    function bit ack_sampled_next();
      return active && !low_half_next && (phase == i2cm_pkg::PH_RACK);
    endfunction

    function void advance_half_bit(logic sda_in, inout i2cm_pkg::rsp_item_t r);
      if (!low_half_next) begin
        low_half_next = 1'b1;
        scl = 1'b1;
        case (phase)
          i2cm_pkg::PH_START: begin
            sda = 1'b0;
            shreg = addr_rw;
            phase = i2cm_pkg::PH_DOUT;
            nbits = '0;
          end
          i2cm_pkg::PH_DOUT: begin
            if (nbits == i2cm_pkg::BitsPerByte) begin
              nbits = '0;
              shreg = '0;
              phase = i2cm_pkg::PH_RACK;
            end
          end
          i2cm_pkg::PH_RACK: begin
            if (!sda_in) begin
              if (addr_rw[0]) begin
                phase = i2cm_pkg::PH_DIN;
              end else if (fill > 0) begin
                shreg = txq[head];
                head = (head + 1) % qdepth;
                fill--;
                phase = i2cm_pkg::PH_DOUT;
              end else begin
                phase = i2cm_pkg::PH_STOP;
              end
            end else begin
              phase = i2cm_pkg::PH_STOP;
              status = i2cm_pkg::ST_ERR;
            end
          end
          i2cm_pkg::PH_DIN: begin
            shreg = {shreg[6:0], sda_in};
            nbits = nbits + 4'd1;
            if (nbits == i2cm_pkg::BitsPerByte) begin
              nbits = '0;
              r.rx_byte = shreg;
              r.rx_valid = 1'b1;
              shreg = '0;
              rx_left = rx_left - 16'd1;
              phase = (rx_left == 0) ? i2cm_pkg::PH_STOP : i2cm_pkg::PH_GACK;
            end
          end
          i2cm_pkg::PH_GACK: phase = i2cm_pkg::PH_DIN;
          i2cm_pkg::PH_STOP: begin
            sda = 1'b1;
            active = 1'b0;
            phase = i2cm_pkg::PH_START;
            low_half_next = 1'b0;
            if (status != i2cm_pkg::ST_ERR) status = i2cm_pkg::ST_OK;
            r.done_res = 1'b1;
          end
          default: ;
        endcase
      end else begin
        low_half_next = 1'b0;
        scl = 1'b0;
        case (phase)
          i2cm_pkg::PH_DOUT: begin
            sda = shreg[7];
            shreg = {shreg[6:0], 1'b0};
            nbits = nbits + 4'd1;
          end
          i2cm_pkg::PH_RACK, i2cm_pkg::PH_DIN: sda = 1'b1;
          i2cm_pkg::PH_GACK, i2cm_pkg::PH_STOP: sda = 1'b0;
          default: ;
        endcase
      end
    endfunction

    function void note_request(i2cm_pkg::cmd_item_t c);
      i2cm_pkg::rsp_item_t r;
      r = '0;
      case (c.operation)
        i2cm_pkg::OP_TICK: begin
          if (active) advance_half_bit(c.sda_in, r);
        end
        i2cm_pkg::OP_PUSH: begin
          if (fill >= qdepth) begin
            r.push_dropped = 1'b1;
          end else begin
            txq[tail] = c.data_byte;
            tail = (tail + 1) % qdepth;
            fill++;
          end
        end
        i2cm_pkg::OP_START: begin
          if (!active) begin
            addr_rw = c.data_byte;
            rx_left = c.receive_count;
            nbits = '0;
            shreg = '0;
            phase = i2cm_pkg::PH_START;
            status = i2cm_pkg::ST_BUSY;
            active = 1'b1;
          end
        end
        default: ;
      endcase
      r.scl_out = scl;
      r.sda_out = sda;
      r.bus_status = status;
      expected_rsp.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_response(i2cm_pkg::rsp_item_t got);
      i2cm_pkg::rsp_item_t exp_r;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = expected_rsp.pop_front();
      compare_field("scl_out", exp_r.scl_out, got.scl_out);
      compare_field("sda_out", exp_r.sda_out, got.sda_out);
      compare_field("rx_byte", exp_r.rx_byte, got.rx_byte);
      compare_field("rx_valid", exp_r.rx_valid, got.rx_valid);
      compare_field("done_res", exp_r.done_res, got.done_res);
      compare_field("bus_status", exp_r.bus_status, got.bus_status);
      compare_field("push_dropped", exp_r.push_dropped, got.push_dropped);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycle_count = 0;
  int work_items = 0;
  int tx_left = 0;
  bit tx_calm = 1'b0;
  int rx_left = 0;
  bit rx_calm = 1'b0;

  i2c_bit_scoreboard sb;

  i2cm_if #(.payload_t(i2cm_pkg::cmd_item_t)) cmd_ch ();
  i2cm_if #(.payload_t(i2cm_pkg::rsp_item_t)) rsp_ch ();

  i2c_master_bit_engine #(.TX_QUEUE_DEPTH(QDEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // runs of gapless requests and runs of random gaps are drawn at random
  function automatic int draw_gap(inout int left, inout bit calm);
    if (left == 0) begin
      left = int'($urandom_range(8, 60));
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  task automatic send_item(logic [1:0] op, logic sda_v, logic [7:0] data_v,
                           logic [15:0] cnt_v);
    i2cm_pkg::cmd_item_t req;
    int gap;
    req.operation = op;
    req.sda_in = sda_v;
    req.data_byte = data_v;
    req.receive_count = cnt_v;
    if ((op == i2cm_pkg::OP_PUSH) || (op == i2cm_pkg::OP_TICK && sb.active) ||
        (op == i2cm_pkg::OP_START && !sb.active))
      work_items++;
    gap = draw_gap(tx_left, tx_calm);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= req;
    do @(negedge clk); while (!cmd_ch.ready);
    sb.note_request(req);
    @(posedge clk);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_item(i2cm_pkg::OP_PUSH, 1'($urandom_range(0, 1)), 8'($urandom),
                   16'($urandom));
      1: begin
        // only while busy, so the start is dropped
        if (sb.active) send_item(i2cm_pkg::OP_START, 1'($urandom_range(0, 1)),
                                 8'($urandom), 16'($urandom));
        else send_item(OP_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
      end
      2: send_item(OP_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom));
      default: send_item(i2cm_pkg::OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom),
                         16'($urandom));
    endcase
  endtask

  task automatic drive_transfer(int max_ticks, ack_plan_t plan, bit noisy);
    int n_ticks;
    bit addr_slot;
    logic sda_v;
    n_ticks = 0;
    addr_slot = 1'b1;
    while (sb.active && n_ticks < max_ticks) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        send_noise();
      end else begin
        sda_v = 1'($urandom_range(0, 1));
        if (sb.ack_sampled_next()) begin
          case (plan)
            NACK_ADDRESS: sda_v = addr_slot ? 1'b1 : ($urandom_range(0, 9) == 0);
            ACK_ALWAYS: sda_v = 1'b0;
            default: sda_v = ($urandom_range(0, 9) == 0);
          endcase
          addr_slot = 1'b0;
        end
        send_item(i2cm_pkg::OP_TICK, sda_v, 8'($urandom), 16'($urandom));
        n_ticks++;
      end
    end
  endtask

  task automatic run_transfer(int xfer);
    int n_push;
    logic [7:0] addr;
    logic [15:0] cnt;
    ack_plan_t plan;
    if (xfer == 0) n_push = 18;
    else if ($urandom_range(0, 7) == 0) n_push = int'($urandom_range(10, 20));
    else n_push = int'($urandom_range(0, 4));
    repeat (n_push) send_item(i2cm_pkg::OP_PUSH, 1'($urandom_range(0, 1)), 8'($urandom),
                              16'($urandom));
    addr = 8'($urandom);
    cnt = 16'($urandom);
    plan = ACK_MOSTLY;
    if (addr[0]) begin
      // long reads only with the address refused
      if ($urandom_range(0, 4) == 0) plan = NACK_ADDRESS;
      else cnt = 16'($urandom_range(1, 3));
    end
    send_item(i2cm_pkg::OP_START, 1'($urandom_range(0, 1)), addr, cnt);
    drive_transfer(100000, plan, 1'b1);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      int gap;
      gap = draw_gap(rx_left, rx_calm);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(negedge clk); while (!rsp_ch.valid);
      sb.check_response(rsp_ch.data);
      @(posedge clk);
    end
  end

  initial begin
    int xfer;
    sb = new(QDEPTH);
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // idle behavior, queue extremes, read count zero, start while busy, nack
    send_item(OP_UNUSED, 1'b1, 8'h5A, 16'h0000);
    send_item(i2cm_pkg::OP_TICK, 1'b0, 8'h00, 16'h0000);
    send_item(i2cm_pkg::OP_PUSH, 1'b0, 8'h00, 16'h0000);
    send_item(i2cm_pkg::OP_PUSH, 1'b1, 8'hFF, 16'hFFFF);
    send_item(i2cm_pkg::OP_START, 1'b0, 8'hFF, 16'h0000);
    send_item(i2cm_pkg::OP_START, 1'b1, 8'h00, 16'hFFFF);
    drive_transfer(64, NACK_ADDRESS, 1'b0);
    drain();

    xfer = 0;
    while (work_items < ITEM_TARGET) begin
      run_transfer(xfer);
      xfer++;
      repeat ($urandom_range(0, 3)) send_noise();
      if ($urandom_range(0, 3) == 0) drain();
    end

    // read count zero wraps: runs well past the first byte without a stop
    drain();
    send_item(i2cm_pkg::OP_START, 1'b0, 8'hA1, 16'h0000);
    drive_transfer(220, ACK_ALWAYS, 1'b0);

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
